FILE: rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rasp_pkg.sv
// types and constants of the record archive stream parser
package rasp_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MAGIC  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DATA_LENGTH = 8'd1;

	localparam logic [31:0] MAGIC_RESET   = 32'h5441_4443;
	localparam logic [31:0] MAX_LEN_RESET = 32'h0010_0000;

	// event kinds
	localparam logic [2:0] KIND_FILE_HDR = 3'd0;
	localparam logic [2:0] KIND_REC_HDR  = 3'd1;
	localparam logic [2:0] KIND_NAME     = 3'd2;
	localparam logic [2:0] KIND_DATA     = 3'd3;
	localparam logic [2:0] KIND_ERROR    = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MAGIC     = 3'd1;
	localparam logic [2:0] ERR_ZERO_NAME = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
	localparam logic [2:0] ERR_TRUNCATED = 3'd4;

	// byte positions inside the headers
	localparam logic [4:0] POS_MAGIC_END   = 5'd3;
	localparam logic [4:0] POS_VERSION_END = 5'd5;
	localparam logic [4:0] POS_FFLAGS_END  = 5'd7;
	localparam logic [4:0] POS_COUNT_END   = 5'd11;
	localparam logic [4:0] POS_SUM_LIMIT   = 5'd20;
	localparam logic [4:0] POS_FHDR_END    = 5'd23;
	localparam logic [4:0] POS_NAME_CNT    = 5'd0;
	localparam logic [4:0] POS_TYPE        = 5'd1;
	localparam logic [4:0] POS_RFLAGS_END  = 5'd3;
	localparam logic [4:0] POS_DLEN_END    = 5'd7;
	localparam logic [4:0] POS_RHDR_END    = 5'd15;

	// depth of the result queue
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_FILE_HDR,
		PH_REC_HDR,
		PH_NAME,
		PH_DATA,
		PH_DONE,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
		logic       end_of_input;
	} stream_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [2:0]  error_code;
		logic        checksum_ok;
		logic [15:0] hdr_version;
		logic [15:0] flag_bits;
		logic [31:0] length_count;
		logic [7:0]  record_kind;
		logic [7:0]  name_length;
		logic [63:0] time_stamp;
		logic [7:0]  payload_byte;
		logic [31:0] record_number;
		logic        last_of_record;
	} event_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [4:0]  byte_position;
		logic [63:0] field_shift;
		logic [31:0] checksum;
		logic [31:0] record_total;
		logic [31:0] records_done;
		logic [7:0]  name_remaining;
		logic [7:0]  name_total;
		logic [31:0] data_remaining;
		logic [31:0] data_length;
		logic [7:0]  record_type;
		logic [15:0] flags;
		logic [15:0] file_version;
	} parse_state_t;

	localparam parse_state_t PARSE_CLEAR = '0;

	// parser to top level
	typedef struct packed {
		logic   push;
		phase_t phase;
	} parse_status_t;

	// result queue to top level
	typedef struct packed {
		logic push;
		logic full;
	} queue_status_t;

endpackage

FILE: rtl/rasp_parser.sv
// byte-wise parse state and result decode of the record archive parser
module rasp_parser import rasp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  stream_item_t  item,
	input  logic [31:0]   expected_magic,
	input  logic [31:0]   max_data_length,
	output event_item_t   result,
	output parse_status_t status
);

	parse_state_t state_q;
	parse_state_t state_eff;
	parse_state_t state_step;
	parse_state_t state_nxt;

	logic [63:0] shift_new;
	logic [31:0] acc_add;
	logic [31:0] acc_rot;
	logic [4:0]  pos;
	logic        active;
	logic        step_active;
	logic        magic_bad;
	logic        name_zero;
	logic        len_bad;
	logic [7:0]  name_dec;
	logic [31:0] data_dec;
	logic [31:0] done_inc;
	logic        truncate;
	logic        have;

	// restart clears everything before the byte is used
	assign state_eff = item.start_of_file ? PARSE_CLEAR : state_q;

	assign shift_new = {item.data_byte, state_eff.field_shift[63:8]};
	assign acc_add   = state_eff.checksum + {24'd0, item.data_byte};
	assign acc_rot   = {acc_add[28:0], acc_add[31:29]};
	assign pos       = state_eff.byte_position;
	assign active    = (state_eff.phase != PH_DONE) && (state_eff.phase != PH_STOP);
	assign magic_bad = (pos == POS_MAGIC_END) && (shift_new[63:32] != expected_magic);
	assign name_zero = (state_eff.name_remaining == 8'd0);
	assign len_bad   = (state_eff.data_length > max_data_length);
	assign name_dec  = state_eff.name_remaining - 8'd1;
	assign data_dec  = state_eff.data_remaining - 32'd1;
	assign done_inc  = state_eff.records_done + 32'd1;

	// next state before the end-of-input check
	always_comb begin
		state_step = state_eff;
		case (state_eff.phase)
			PH_FILE_HDR: begin
				state_step.field_shift = shift_new;
				if (pos < POS_SUM_LIMIT) begin
					state_step.checksum = acc_rot;
				end
				if (magic_bad) begin
					state_step.phase = PH_STOP;
				end else begin
					if (pos == POS_VERSION_END) begin
						state_step.file_version = shift_new[63:48];
					end
					if (pos == POS_FFLAGS_END) begin
						state_step.flags = shift_new[63:48];
					end
					if (pos == POS_COUNT_END) begin
						state_step.record_total = shift_new[63:32];
					end
					if (pos == POS_FHDR_END) begin
						state_step.byte_position = 5'd0;
						state_step.phase = (state_eff.record_total == 32'd0) ?
							PH_DONE : PH_REC_HDR;
					end else begin
						state_step.byte_position = pos + 5'd1;
					end
				end
			end
			PH_REC_HDR: begin
				state_step.field_shift = shift_new;
				if (pos == POS_NAME_CNT) begin
					state_step.name_remaining = item.data_byte;
					state_step.name_total = item.data_byte;
				end
				if (pos == POS_TYPE) begin
					state_step.record_type = item.data_byte;
				end
				if (pos == POS_RFLAGS_END) begin
					state_step.flags = shift_new[63:48];
				end
				if (pos == POS_DLEN_END) begin
					state_step.data_length = shift_new[63:32];
				end
				if (pos == POS_RHDR_END) begin
					if (name_zero || len_bad) begin
						state_step.phase = PH_STOP;
					end else begin
						state_step.data_remaining = state_eff.data_length;
						state_step.byte_position = 5'd0;
						state_step.phase = PH_NAME;
					end
				end else begin
					state_step.byte_position = pos + 5'd1;
				end
			end
			PH_NAME: begin
				state_step.field_shift = shift_new;
				state_step.name_remaining = name_dec;
				if (name_dec == 8'd0) begin
					if (state_eff.data_remaining == 32'd0) begin
						state_step.records_done = done_inc;
						state_step.byte_position = 5'd0;
						state_step.phase = (done_inc == state_eff.record_total) ?
							PH_DONE : PH_REC_HDR;
					end else begin
						state_step.phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				state_step.field_shift = shift_new;
				state_step.data_remaining = data_dec;
				if (data_dec == 32'd0) begin
					state_step.records_done = done_inc;
					state_step.byte_position = 5'd0;
					state_step.phase = (done_inc == state_eff.record_total) ?
						PH_DONE : PH_REC_HDR;
				end
			end
			default: begin
				state_step = state_eff;
			end
		endcase
	end

	assign step_active = (state_step.phase != PH_DONE) && (state_step.phase != PH_STOP);
	assign truncate    = active && item.end_of_input && step_active;

	always_comb begin
		state_nxt = state_step;
		if (truncate) begin
			state_nxt.phase = PH_STOP;
		end
	end

	// result fields
	always_comb begin
		result = '0;
		have = 1'b0;
		result.record_number = state_eff.records_done;
		result.hdr_version = state_step.file_version;
		case (state_eff.phase)
			PH_FILE_HDR: begin
				if (magic_bad) begin
					result.event_kind = KIND_ERROR;
					result.error_code = ERR_MAGIC;
					have = 1'b1;
				end else if (pos == POS_FHDR_END) begin
					result.event_kind = KIND_FILE_HDR;
					result.checksum_ok = (state_eff.checksum == shift_new[63:32]);
					result.flag_bits = state_eff.flags;
					result.length_count = state_eff.record_total;
					have = 1'b1;
				end
			end
			PH_REC_HDR: begin
				if (pos == POS_RHDR_END) begin
					if (name_zero || len_bad) begin
						result.event_kind = KIND_ERROR;
						result.error_code = name_zero ? ERR_ZERO_NAME : ERR_TOO_LONG;
					end else begin
						result.event_kind = KIND_REC_HDR;
						result.flag_bits = state_eff.flags;
						result.length_count = state_eff.data_length;
						result.record_kind = state_eff.record_type;
						result.name_length = state_eff.name_total;
						result.time_stamp = shift_new;
					end
					have = 1'b1;
				end
			end
			PH_NAME: begin
				result.event_kind = KIND_NAME;
				result.record_kind = state_eff.record_type;
				result.name_length = state_eff.name_total;
				result.payload_byte = item.data_byte;
				result.last_of_record = (name_dec == 8'd0) &&
					(state_eff.data_remaining == 32'd0);
				have = 1'b1;
			end
			PH_DATA: begin
				result.event_kind = KIND_DATA;
				result.record_kind = state_eff.record_type;
				result.name_length = state_eff.name_total;
				result.payload_byte = item.data_byte;
				result.last_of_record = (data_dec == 32'd0);
				have = 1'b1;
			end
			default: begin
				have = 1'b0;
			end
		endcase
		if (truncate) begin
			if (!have) begin
				result.event_kind = KIND_ERROR;
			end
			result.error_code = ERR_TRUNCATED;
			have = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_CLEAR;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	assign status.push  = accept && have;
	assign status.phase = state_q.phase;

endmodule

FILE: rtl/rasp_event_queue.sv
// two-entry result queue between the parser and the event channel
module rasp_event_queue import rasp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  event_item_t   push_item,
	output logic          event_valid,
	input  logic          event_ready,
	output event_item_t   event_item,
	output queue_status_t status
);

	event_item_t            entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   pop;

	assign event_valid = (count_q != '0);
	assign event_item  = entries_q[rd_ptr_q];
	assign pop         = event_valid && event_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

	assign status.push = push;
	assign status.full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));

endmodule

FILE: rtl/record_archive_stream_parser.sv
// top level of the record archive stream parser
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+-----------------------------
//  stream  | stream_valid, stream_ready, stream_item   | one archive byte per transaction
//  event   | event_valid, event_ready, event_item      | zero or one result per byte
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// one byte is taken per cycle while stream_ready is high; its result is in the queue in the cycle after
// the parse state register is updated once per accepted byte
// a two-entry result queue lets bytes keep flowing while a result waits
// stream_ready drops only while both queue entries are occupied
// asynchronous reset restores both registers and clears the parse state
`include "assert_macros.svh"

module record_archive_stream_parser import rasp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   stream_valid,
	output logic                   stream_ready,
	input  stream_item_t           stream_item,
	output logic                   event_valid,
	input  logic                   event_ready,
	output event_item_t            event_item,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	logic [31:0]   magic_q;
	logic [31:0]   max_len_q;
	logic          stream_accept;
	event_item_t   parse_result;
	parse_status_t parse_status;
	queue_status_t queue_status;

	// configuration registers, writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MAGIC_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_EXPECTED_MAGIC:  magic_q   <= cfg_data;
				CFG_MAX_DATA_LENGTH: max_len_q <= cfg_data;
				default: begin
					// indexes beyond the register list are dropped
				end
			endcase
		end
	end

	// a byte goes in whenever the queue has room for its result
	assign stream_ready  = !queue_status.full;
	assign stream_accept = stream_valid && stream_ready;

	rasp_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (stream_accept),
		.item            (stream_item),
		.expected_magic  (magic_q),
		.max_data_length (max_len_q),
		.result          (parse_result),
		.status          (parse_status)
	);

	rasp_event_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (parse_status.push),
		.push_item   (parse_result),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_item  (event_item),
		.status      (queue_status)
	);

	// an error-only result always carries a reason
	`ASSERT_SAME(a_error_has_code, event_valid && (event_item.event_kind == KIND_ERROR), event_item.error_code != ERR_NONE, "error event without error code")

	// end of record is flagged only on name or data bytes
	`ASSERT_SAME(a_last_on_payload, event_valid && event_item.last_of_record, (event_item.event_kind == KIND_NAME) || (event_item.event_kind == KIND_DATA), "last_of_record on a header event")

	// any error halts the parser
	`ASSERT_NEXT(a_error_stops, parse_status.push && (parse_result.error_code != ERR_NONE), parse_status.phase == PH_STOP, "parser still running after an error")

	// a halted parser stays silent until restarted
	`ASSERT_SAME(a_stop_silent, stream_accept && (parse_status.phase == PH_STOP) && !stream_item.start_of_file, !parse_status.push, "result produced while halted")

	// the queue never takes a result it cannot hold
	`ASSERT_SAME(a_no_overflow, queue_status.full && !event_ready, !queue_status.push, "result queue overflow")

endmodule
